FILE: rtl/fpalu_pkg.sv
// Package with the opcode encoding and field widths of the fixed-point ALU.
package fpalu_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_GT      = 4'd4,
    OP_LT      = 4'd5,
    OP_GE      = 4'd6,
    OP_LE      = 4'd7,
    OP_EQ      = 4'd8,
    OP_NE      = 4'd9,
    OP_MIN     = 4'd10,
    OP_MAX     = 4'd11,
    OP_INC     = 4'd12,
    OP_DEC     = 4'd13,
    OP_TOINT   = 4'd14,
    OP_FROMINT = 4'd15
  } opcode_t;

endpackage

FILE: rtl/fpalu_in_if.sv
// Request channel of the fixed-point ALU: opcode and two operands.
interface fpalu_in_if;
  logic                                valid;
  logic                                ready;
  logic [fpalu_pkg::OP_W-1:0]          opcode;
  logic signed [fpalu_pkg::DATA_W-1:0] operand_a;
  logic signed [fpalu_pkg::DATA_W-1:0] operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input opcode, input operand_a, input operand_b,
                output ready);
endinterface

FILE: rtl/fpalu_out_if.sv
// Response channel of the fixed-point ALU: result value and status flags.
interface fpalu_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpalu_pkg::DATA_W-1:0] value;
  logic                                compare_true;
  logic                                divide_by_zero;

  modport source (output valid, output value, output compare_true,
                  output divide_by_zero, input ready);
  modport sink (input valid, input value, input compare_true,
                input divide_by_zero, output ready);
endinterface

FILE: rtl/fixed_point_alu.sv
// Pipelined signed 32-bit fixed-point ALU with a bit-per-stage divider.
//
// Transactions arrive on req (opcode, operand_a, operand_b) and each one
// produces exactly one transaction on rsp (value, compare_true,
// divide_by_zero), in order. Values carry FRAC_BITS fractional bits.
// Every operation goes through the same pipeline: an input stage that holds
// the multiplier product and prepares the divider operands, 32 + FRAC_BITS
// restoring divider stages resolving one quotient bit each, and an output
// register that applies the quotient sign. A new transaction is accepted
// every cycle unless rsp is stalled; the divider stages set the pipeline
// depth.
// Reset clears all valid bits, so no response appears until new requests
// are taken. When the receiver holds rsp.ready low while a response is
// waiting, the whole pipeline freezes and req.ready falls in the same cycle;
// nothing is lost or repeated, and flow resumes as soon as ready returns.
// Division by zero returns zero with divide_by_zero set.
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic         clk,
  input  logic         rst,
  fpalu_in_if.sink     req,
  fpalu_out_if.source  rsp
);

  localparam int unsigned DW = fpalu_pkg::DATA_W;
  localparam int unsigned NW = DW + FRAC_BITS;

  typedef struct packed {
    logic                 is_div;
    logic                 is_mul;
    logic                 neg;
    logic                 dz;
    logic                 cmp;
    logic signed [DW-1:0] val;
  } side_t;

  logic en;

  logic signed [DW-1:0]   a;
  logic signed [DW-1:0]   b;
  fpalu_pkg::opcode_t     op;
  side_t                  side_next;
  logic signed [2*DW-1:0] prod_next;
  logic signed [NW-1:0]   num_s;
  logic [NW-1:0]          num_next;
  logic [DW-1:0]          den_next;

  logic signed [2*DW-1:0] prod;

  logic              valid [0:NW];
  side_t             side  [0:NW];
  logic [DW-1:0]     rem   [0:NW];
  logic [NW-1:0]     num   [0:NW];
  logic [DW-1:0]     den   [0:NW];
  logic [DW-1:0]     quo   [0:NW];

  logic [DW-1:0]     div_val;

  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  assign a  = req.operand_a;
  assign b  = req.operand_b;
  assign op = fpalu_pkg::opcode_t'(req.opcode);

  assign prod_next = a * b;
  assign num_s     = NW'(a) <<< FRAC_BITS;
  assign num_next  = a[DW-1] ? NW'(-num_s) : NW'(num_s);
  assign den_next  = b[DW-1] ? DW'(-b) : DW'(b);

  always_comb begin
    side_next        = '0;
    side_next.neg    = a[DW-1] ^ b[DW-1];
    case (op)
      fpalu_pkg::OP_ADD:     side_next.val = a + b;
      fpalu_pkg::OP_SUB:     side_next.val = a - b;
      fpalu_pkg::OP_MUL:     side_next.is_mul = 1'b1;
      fpalu_pkg::OP_DIV: begin
        side_next.is_div = 1'b1;
        side_next.dz     = (b == '0);
      end
      fpalu_pkg::OP_GT:      side_next.cmp = (a > b);
      fpalu_pkg::OP_LT:      side_next.cmp = (a < b);
      fpalu_pkg::OP_GE:      side_next.cmp = (a >= b);
      fpalu_pkg::OP_LE:      side_next.cmp = (a <= b);
      fpalu_pkg::OP_EQ:      side_next.cmp = (a == b);
      fpalu_pkg::OP_NE:      side_next.cmp = (a != b);
      fpalu_pkg::OP_MIN:     side_next.val = (a < b) ? a : b;
      fpalu_pkg::OP_MAX:     side_next.val = (a > b) ? a : b;
      fpalu_pkg::OP_INC:     side_next.val = a + DW'(1);
      fpalu_pkg::OP_DEC:     side_next.val = a - DW'(1);
      fpalu_pkg::OP_TOINT:   side_next.val = a >>> FRAC_BITS;
      fpalu_pkg::OP_FROMINT: side_next.val = a << FRAC_BITS;
      default:               side_next.val = '0;
    endcase
  end

  // Input stage: product, simple results and divider operand magnitudes.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_next;
      prod    <= prod_next;
      rem[0]  <= '0;
      num[0]  <= num_next;
      den[0]  <= den_next;
      quo[0]  <= '0;
    end
  end

  // Restoring divider, one quotient bit per stage, numerator taken MSB first.
  for (genvar k = 1; k <= NW; k++) begin : g_div
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        qbit;
    side_t       side_in;

    assign trial = {rem[k-1], num[k-1][NW-1]};
    assign diff  = trial - {1'b0, den[k-1]};
    assign qbit  = !diff[DW];

    always_comb begin
      side_in = side[k-1];
      if (k == 1 && side[k-1].is_mul) begin
        side_in.val = prod[FRAC_BITS +: DW];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (en) begin
        valid[k] <= valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side[k] <= side_in;
        rem[k]  <= qbit ? diff[DW-1:0] : trial[DW-1:0];
        num[k]  <= num[k-1] << 1;
        den[k]  <= den[k-1];
        quo[k]  <= {quo[k-1][DW-2:0], qbit};
      end
    end
  end

  assign div_val = side[NW].neg ? DW'(-quo[NW]) : quo[NW];

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= valid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (side[NW].is_div) begin
        rsp.value <= side[NW].dz ? '0 : div_val;
      end else begin
        rsp.value <= side[NW].val;
      end
      rsp.compare_true   <= side[NW].cmp;
      rsp.divide_by_zero <= side[NW].dz;
    end
  end

endmodule

FILE: rtl/fpalu_checker.sv
// Port-level checker for the fixed-point ALU and its bind statement.
module fpalu_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                rsp_valid,
  input logic                                rsp_ready,
  input logic signed [fpalu_pkg::DATA_W-1:0] rsp_value,
  input logic                                rsp_compare_true,
  input logic                                rsp_divide_by_zero
);

  // A stalled response stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("Response withdrawn while stalled.");

  // A stalled response keeps its contents.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_compare_true)
      && $stable(rsp_divide_by_zero))
    else $error("Response changed while stalled.");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("Response offered straight after reset.");

  // Division by zero yields a zero value and no comparison outcome.
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_divide_by_zero |-> rsp_value == '0 && !rsp_compare_true)
    else $error("Division by zero returned a non-zero result.");

  // A true comparison carries a zero value.
  a_cmp_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_compare_true |-> rsp_value == '0 && !rsp_divide_by_zero)
    else $error("Comparison result carried a value.");

endmodule

bind fixed_point_alu fpalu_checker u_fpalu_checker (
  .clk                (clk),
  .rst                (rst),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_value          (rsp.value),
  .rsp_compare_true   (rsp.compare_true),
  .rsp_divide_by_zero (rsp.divide_by_zero)
);

FILE: bench/tb_top.sv
// Self-checking testbench for the pipelined fixed-point ALU.
module tb_top;
  import fpalu_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 11;
  localparam int FRAC             = 8;
  localparam int IDLE_PCT         = 7;
  localparam int HOLD_CYCLES      = 400;
  localparam int DRAIN_CYCLES     = 80;
  localparam int TIMEOUT_CYCLES   = 200000;
  localparam int NUM_DIRECTED     = 25;
  localparam int RANDOM_OPEN      = 650;
  localparam int RANDOM_HELD      = 250;
  localparam int RANDOM_BURST     = 300;
  localparam int RANDOM_CLOSE     = 225;

  typedef struct packed {
    opcode_t             opcode;
    logic [DATA_W-1:0]   a;
    logic [DATA_W-1:0]   b;
  } alu_op_t;

  typedef struct packed {
    logic [DATA_W-1:0]   value;
    logic                compare_true;
    logic                divide_by_zero;
  } alu_result_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [DATA_W-1:0]   a;
    logic [DATA_W-1:0]   b;
    logic                known;
    logic [DATA_W-1:0]   value;
    logic                compare_true;
    logic                divide_by_zero;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst;
  int   idle_pct;
  logic hold_rsp;
  logic hold_done;
  int   mismatch_count = 0;
  alu_result_t pending_alu_results [$];

  fpalu_in_if  req ();
  fpalu_out_if rsp ();

  fixed_point_alu #(.FRAC_BITS(FRAC)) u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_ADD,     32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 32'h8000_0000, 1'b0, 1'b0},
    '{OP_SUB,     32'h8000_0000, 32'h0000_0001, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
    '{OP_MUL,     32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0,         1'b0, 1'b0},
    '{OP_MUL,     32'h8000_0000, 32'h8000_0000, 1'b1, 32'h0,         1'b0, 1'b0},
    '{OP_MUL,     32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0,         1'b0, 1'b0},
    '{OP_MUL,     32'h0000_0180, 32'hFFFF_FE00, 1'b0, 32'h0,         1'b0, 1'b0},
    '{OP_DIV,     32'h1234_5678, 32'h0000_0000, 1'b1, 32'h0,         1'b0, 1'b1},
    '{OP_DIV,     32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0,         1'b0, 1'b1},
    '{OP_DIV,     32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0,         1'b0, 1'b0},
    '{OP_DIV,     32'h0000_0300, 32'h0000_0200, 1'b0, 32'h0,         1'b0, 1'b0},
    '{OP_DIV,     32'hFFFF_FFFF, 32'h0000_0300, 1'b0, 32'h0,         1'b0, 1'b0},
    '{OP_GT,      32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0,         1'b0, 1'b0},
    '{OP_LT,      32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0,         1'b1, 1'b0},
    '{OP_GE,      32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0,         1'b0, 1'b0},
    '{OP_LE,      32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0,         1'b1, 1'b0},
    '{OP_EQ,      32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h0,         1'b1, 1'b0},
    '{OP_NE,      32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h0,         1'b1, 1'b0},
    '{OP_MIN,     32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 1'b0, 1'b0},
    '{OP_MAX,     32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
    '{OP_MIN,     32'h0000_0500, 32'h0000_0500, 1'b0, 32'h0,         1'b0, 1'b0},
    '{OP_INC,     32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 1'b0, 1'b0},
    '{OP_DEC,     32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b0, 1'b0},
    '{OP_TOINT,   32'h8000_0000, 32'h0000_0000, 1'b1, 32'hFF80_0000, 1'b0, 1'b0},
    '{OP_TOINT,   32'hFFFF_FF01, 32'h5A5A_5A5A, 1'b0, 32'h0,         1'b0, 1'b0},
    '{OP_FROMINT, 32'h0080_0000, 32'h0000_0000, 1'b1, 32'h8000_0000, 1'b0, 1'b0}
  };

  function automatic alu_result_t fixed_point_result(alu_op_t op);
    alu_result_t                 r;
    logic signed [DATA_W-1:0]    sa;
    logic signed [DATA_W-1:0]    sb;
    logic signed [2*DATA_W-1:0]  wide_a;
    logic signed [2*DATA_W-1:0]  wide_b;
    logic signed [2*DATA_W-1:0]  wide_r;
    sa     = op.a;
    sb     = op.b;
    wide_a = sa;
    wide_b = sb;
    wide_r = '0;
    r      = '0;
    case (op.opcode)
      OP_ADD:     r.value = sa + sb;
      OP_SUB:     r.value = sa - sb;
      OP_MUL: begin
        wide_r  = (wide_a * wide_b) >>> FRAC;
        r.value = wide_r[DATA_W-1:0];
      end
      OP_DIV: begin
        if (sb == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          wide_r  = (wide_a <<< FRAC) / wide_b;
          r.value = wide_r[DATA_W-1:0];
        end
      end
      OP_GT:      r.compare_true = sa > sb;
      OP_LT:      r.compare_true = sa < sb;
      OP_GE:      r.compare_true = sa >= sb;
      OP_LE:      r.compare_true = sa <= sb;
      OP_EQ:      r.compare_true = sa == sb;
      OP_NE:      r.compare_true = sa != sb;
      OP_MIN:     r.value = (sa < sb) ? sa : sb;
      OP_MAX:     r.value = (sa > sb) ? sa : sb;
      OP_INC:     r.value = sa + 1;
      OP_DEC:     r.value = sa - 1;
      OP_TOINT:   r.value = sa >>> FRAC;
      OP_FROMINT: r.value = sa << FRAC;
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] random_operand();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 5) begin
      return $urandom();
    end
    if (pick < 8) begin
      return DATA_W'(int'($urandom_range(4095)) - 2048);
    end
    case ($urandom_range(4))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return 32'h0000_0100;
    endcase
  endfunction

  function automatic alu_op_t random_alu_op();
    alu_op_t op;
    op.opcode = opcode_t'($urandom_range(15));
    op.a      = random_operand();
    op.b      = ($urandom_range(9) == 0) ? op.a : random_operand();
    if (op.opcode == OP_DIV && $urandom_range(7) == 0) begin
      op.b = '0;
    end
    return op;
  endfunction

  task automatic send_alu_op(input alu_op_t op, input alu_result_t expected);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.opcode    <= op.opcode;
    req.operand_a <= op.a;
    req.operand_b <= op.b;
    do @(posedge clk); while (!req.ready);
    pending_alu_results.push_back(expected);
    @(negedge clk);
  endtask

  task automatic send_random_ops(input int count);
    alu_op_t op;
    repeat (count) begin
      op = random_alu_op();
      send_alu_op(op, fixed_point_result(op));
    end
  endtask

  task automatic wait_for_drain();
    while (pending_alu_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    alu_op_t     op;
    alu_result_t expected;
    rst           = 1'b1;
    req.valid     = 1'b0;
    req.opcode    = OP_ADD;
    req.operand_a = '0;
    req.operand_b = '0;
    idle_pct      = IDLE_PCT;
    hold_rsp      = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      op = '{directed_rows[i].opcode, directed_rows[i].a, directed_rows[i].b};
      if (directed_rows[i].known) begin
        expected = '{directed_rows[i].value, directed_rows[i].compare_true,
                     directed_rows[i].divide_by_zero};
      end else begin
        expected = fixed_point_result(op);
      end
      send_alu_op(op, expected);
    end

    // The sender stops until the pipeline has emptied before random traffic starts.
    req.valid <= 1'b0;
    wait_for_drain();

    send_random_ops(RANDOM_OPEN);
    hold_rsp = 1'b1;
    send_random_ops(RANDOM_HELD);
    idle_pct = 0;
    send_random_ops(RANDOM_BURST);
    idle_pct = IDLE_PCT;
    send_random_ops(RANDOM_CLOSE);

    req.valid <= 1'b0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // The receiver stalls once for a long stretch so that the pipeline fills and freezes.
  initial begin
    rsp.ready = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp && !hold_done) begin
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done = 1'b1;
      end else begin
        rsp.ready <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    alu_result_t expected;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_alu_results.size() == 0) begin
        $display("%0t: unexpected transaction: value %h compare_true %b divide_by_zero %b",
                 $time, rsp.value, rsp.compare_true, rsp.divide_by_zero);
        mismatch_count++;
      end else begin
        expected = pending_alu_results.pop_front();
        if (rsp.value !== expected.value) begin
          $display("%0t: value mismatch: expected %h, actual %h",
                   $time, expected.value, rsp.value);
          mismatch_count++;
        end
        if (rsp.compare_true !== expected.compare_true) begin
          $display("%0t: compare_true mismatch: expected %b, actual %b",
                   $time, expected.compare_true, rsp.compare_true);
          mismatch_count++;
        end
        if (rsp.divide_by_zero !== expected.divide_by_zero) begin
          $display("%0t: divide_by_zero mismatch: expected %b, actual %b",
                   $time, expected.divide_by_zero, rsp.divide_by_zero);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
rtl/fpalu_pkg.sv
rtl/fpalu_in_if.sv
rtl/fpalu_out_if.sv
rtl/fixed_point_alu.sv
rtl/fpalu_checker.sv
bench/tb_top.sv
